// ===== rtl/prf_pkg.sv =====
// Shared constants for the FIFO/LRU page replacement block.
package prf_pkg;

	localparam int PAGE_IN_W  = 8;
	localparam int FRAMES_W   = 4;
	localparam int FAULT_W    = 16;
	localparam int CFG_ADDR_W = 3;
	localparam int REG_IDX_W  = 1;
	localparam int PDATA_W    = 32;

	localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

	localparam logic [REG_IDX_W-1:0] REG_POLICY_MODE   = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'd1;

	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	localparam logic                POLICY_RESET = POLICY_LRU;
	localparam logic [FRAMES_W-1:0] FRAMES_RESET = 4'd3;

endpackage

// ===== rtl/page_replacement_fifo_lru.sv =====
// Page replacement tracker with FIFO or LRU ordering and a saturating fault counter.
//
// Each beat on the input channel is one page reference, and each produces exactly one
// result beat with a hit flag and the fault count after that reference. A reference is
// held in an input register, then looked up and the resident list is updated, and the
// result lands in an output register. A new reference is taken every cycle unless the
// output register holds a result that the receiver is stalling. Frames beyond
// frames_in_use are not used; a value of 0 acts as 1 and values above FRAME_SLOTS act as
// FRAME_SLOTS. The list needs no clearing after reset, since only entries below the
// occupancy are looked at.
// Configuration (policy_mode at 0x0, frames_in_use at 0x4) should be written while idle.
module page_replacement_fifo_lru #(
	parameter int FRAME_SLOTS = 8,
	parameter int PAGE_BITS   = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [prf_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [prf_pkg::PDATA_W-1:0]      pwdata,
	output logic [prf_pkg::PDATA_W-1:0]      prdata,
	output logic                             pready,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [prf_pkg::PAGE_IN_W-1:0]    page_number,

	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             hit,
	output logic [prf_pkg::FAULT_W-1:0]      fault_count
);

	localparam int IDX_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
	localparam int OCC_W = $clog2(FRAME_SLOTS + 1);

	// Configuration registers.
	logic                           policy_q;
	logic [prf_pkg::FRAMES_W-1:0]   frames_q;
	logic [prf_pkg::REG_IDX_W-1:0]  reg_idx;
	logic                           cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[prf_pkg::CFG_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= prf_pkg::POLICY_RESET;
			frames_q <= prf_pkg::FRAMES_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				prf_pkg::REG_POLICY_MODE:   policy_q <= pwdata[0];
				prf_pkg::REG_FRAMES_IN_USE: frames_q <= pwdata[prf_pkg::FRAMES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			prf_pkg::REG_POLICY_MODE:   prdata[0] = policy_q;
			prf_pkg::REG_FRAMES_IN_USE: prdata[prf_pkg::FRAMES_W-1:0] = frames_q;
			default: prdata = '0;
		endcase
	end

	// Input register and handshake.
	logic                 valid_s1;
	logic [PAGE_BITS-1:0] page_s1;
	logic                 valid_s2;
	logic                 hit_s2;
	logic [prf_pkg::FAULT_W-1:0] fault_s2;
	logic                 advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			page_s1 <= PAGE_BITS'(page_number);
		end
	end

	// Resident list state, index 0 holds the oldest page.
	logic [PAGE_BITS-1:0] pages_q [FRAME_SLOTS];
	logic [OCC_W-1:0]     occ_q;
	logic [prf_pkg::FAULT_W-1:0] faults_q;

	logic [OCC_W-1:0]     cap;
	logic [OCC_W-1:0]     drop;
	logic                 full;
	logic [FRAME_SLOTS-1:0] match;
	logic [IDX_W-1:0]     found;
	logic                 is_hit;
	logic [PAGE_BITS-1:0] pages_nxt [FRAME_SLOTS];
	logic [OCC_W-1:0]     occ_nxt;
	logic [prf_pkg::FAULT_W-1:0] faults_nxt;

	always_comb begin
		if (frames_q == '0) begin
			cap = OCC_W'(1);
		end else if (int'(frames_q) > FRAME_SLOTS) begin
			cap = OCC_W'(FRAME_SLOTS);
		end else begin
			cap = OCC_W'(frames_q);
		end
		full = (occ_q >= cap);
		// Entries to drop from the front on a miss; more than one only after the
		// frame count was lowered below the occupancy.
		drop = occ_q - cap + OCC_W'(1);
	end

	always_comb begin
		found = '0;
		for (int i = 0; i < FRAME_SLOTS; i++) begin
			match[i] = (i < int'(occ_q)) && (pages_q[i] == page_s1);
		end
		for (int i = FRAME_SLOTS - 1; i >= 0; i--) begin
			if (match[i]) begin
				found = IDX_W'(i);
			end
		end
		is_hit = |match;
	end

	always_comb begin
		for (int i = 0; i < FRAME_SLOTS; i++) begin
			pages_nxt[i] = pages_q[i];
			if (is_hit) begin
				// LRU closes the gap behind the hit page and puts it at the back.
				if (policy_q == prf_pkg::POLICY_LRU && i >= int'(found)) begin
					if (i + 1 < int'(occ_q)) begin
						if (i < FRAME_SLOTS - 1) begin
							pages_nxt[i] = pages_q[IDX_W'(i + 1)];
						end
					end else if (i + 1 == int'(occ_q)) begin
						pages_nxt[i] = page_s1;
					end
				end
			end else if (!full) begin
				if (i == int'(occ_q)) begin
					pages_nxt[i] = page_s1;
				end
			end else begin
				if (i < int'(cap) - 1) begin
					pages_nxt[i] = pages_q[IDX_W'(i + int'(drop))];
				end else if (i == int'(cap) - 1) begin
					pages_nxt[i] = page_s1;
				end
			end
		end

		occ_nxt    = occ_q;
		faults_nxt = faults_q;
		if (!is_hit) begin
			occ_nxt = full ? cap : occ_q + OCC_W'(1);
			if (faults_q != prf_pkg::FAULT_MAX) begin
				faults_nxt = faults_q + prf_pkg::FAULT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			faults_q <= '0;
		end else if (advance) begin
			occ_q    <= occ_nxt;
			faults_q <= faults_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < FRAME_SLOTS; i++) begin
				pages_q[i] <= pages_nxt[i];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_s2   <= is_hit;
			fault_s2 <= faults_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign hit         = hit_s2;
	assign fault_count = fault_s2;

endmodule

// ===== rtl/prf_checker.sv =====
// Port-level checks for the page replacement block and the bind that attaches them.
module prf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           hit,
	input logic [prf_pkg::FAULT_W-1:0]    fault_count
);

	logic                        seen_q;
	logic [prf_pkg::FAULT_W-1:0] last_fc_q;
	logic                        out_beat;
	logic [prf_pkg::FAULT_W:0]   last_plus;

	assign out_beat  = out_valid && out_ready;
	assign last_plus = {1'b0, last_fc_q} + (prf_pkg::FAULT_W + 1)'(1);

	// Remember the fault count of the last result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			last_fc_q <= '0;
		end else if (out_beat) begin
			seen_q    <= 1'b1;
			last_fc_q <= fault_count;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(fault_count))
		else $error("result beat changed while stalled");

	a_first_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && !seen_q |-> !hit && fault_count == prf_pkg::FAULT_W'(1))
		else $error("first result after reset is not a fault with count one");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && seen_q && hit |-> fault_count == last_fc_q)
		else $error("fault count moved on a hit");

	a_miss_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && seen_q && !hit |->
			(last_fc_q == prf_pkg::FAULT_MAX && fault_count == prf_pkg::FAULT_MAX) ||
			(last_fc_q != prf_pkg::FAULT_MAX &&
			 {1'b0, fault_count} == last_plus))
		else $error("fault count did not step by one on a fault");

endmodule

bind page_replacement_fifo_lru prf_checker u_prf_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for the FIFO/LRU page replacement tracker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 8;

	typedef enum logic {ROW_REF, ROW_CFG} row_kind_e;

	typedef struct {
		row_kind_e                       kind;
		logic [prf_pkg::REG_IDX_W-1:0]   reg_idx;
		logic [7:0]                      val;
		bit                              typed;
		logic                            t_hit;
		logic [prf_pkg::FAULT_W-1:0]     t_count;
	} script_row_t;

	typedef struct {
		logic                        was_hit;
		logic [prf_pkg::FAULT_W-1:0] count;
	} lookup_t;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [prf_pkg::CFG_ADDR_W-1:0]  paddr;
	logic [prf_pkg::PDATA_W-1:0]     pwdata;
	logic [prf_pkg::PDATA_W-1:0]     prdata;
	logic                            pready;
	logic                            in_valid;
	logic                            in_ready;
	logic [prf_pkg::PAGE_IN_W-1:0]   page_number;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic                            hit;
	logic [prf_pkg::FAULT_W-1:0]     fault_count;

	// Travels with each input beat: a typed-in expectation overrides the prediction.
	logic                            row_typed = 1'b0;
	logic                            row_hit = 1'b0;
	logic [prf_pkg::FAULT_W-1:0]     row_count = '0;

	// Predicted block state and configuration.
	logic [prf_pkg::PAGE_IN_W-1:0]   resident [SLOTS];
	int                              resident_count;
	logic [prf_pkg::FAULT_W-1:0]     fault_tally;
	logic                            cfg_policy;
	logic [prf_pkg::FRAMES_W-1:0]    cfg_frames;

	lookup_t                lookups_due [$];
	int                     mismatches = 0;
	int                     beats_checked = 0;
	int                     hits_seen = 0;
	logic [15:0]            frames_visited = '0;
	int                     burst_left = 0;
	int                     rx_left = 0;
	bit                     rx_on = 1'b0;

	script_row_t directed_rows [31] = '{
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'h00, 1'b1, 1'b0, 16'd1},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'hFF, 1'b1, 1'b0, 16'd2},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'h00, 1'b1, 1'b1, 16'd2},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'hAA, 1'b1, 1'b0, 16'd3},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'h55, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'hFF, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'h55, 1'b0, 1'b0, 16'd0},
		'{ROW_CFG, prf_pkg::REG_POLICY_MODE, 8'(prf_pkg::POLICY_FIFO), 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'hAA, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'h80, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'hAA, 1'b0, 1'b0, 16'd0},
		'{ROW_CFG, prf_pkg::REG_FRAMES_IN_USE, 8'd8, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'h10, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'h20, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'h40, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'h80, 1'b0, 1'b0, 16'd0},
		'{ROW_CFG, prf_pkg::REG_FRAMES_IN_USE, 8'd2, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'h40, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'h7F, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'h80, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'h7F, 1'b0, 1'b0, 16'd0},
		'{ROW_CFG, prf_pkg::REG_FRAMES_IN_USE, 8'd0, 1'b0, 1'b0, 16'd0},
		'{ROW_CFG, prf_pkg::REG_POLICY_MODE, 8'(prf_pkg::POLICY_LRU), 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'h7F, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'h33, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'h33, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'hFF, 1'b0, 1'b0, 16'd0},
		'{ROW_CFG, prf_pkg::REG_FRAMES_IN_USE, 8'd15, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'hFE, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'h01, 1'b0, 1'b0, 16'd0},
		'{ROW_REF, prf_pkg::REG_POLICY_MODE, 8'hFE, 1'b0, 1'b0, 16'd0}
	};

	page_replacement_fifo_lru #(
		.FRAME_SLOTS(SLOTS),
		.PAGE_BITS(prf_pkg::PAGE_IN_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.page_number(page_number),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.fault_count(fault_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// About 1.4k references are sent; the timeout allows several times the time they
	// need.
	initial begin
		#500_000;
		$display("testbench NOT OK");
		$finish;
	end

	function automatic int frames_effective(input logic [prf_pkg::FRAMES_W-1:0] setting);
		if (setting == 0)
			return 1;
		if (setting > SLOTS)
			return SLOTS;
		return int'(setting);
	endfunction

	// Looks the page up in the predicted list and applies the replacement policy.
	function automatic void page_lookup(input logic [prf_pkg::PAGE_IN_W-1:0] pg,
			output lookup_t res);
		int cap;
		int at;
		int drop;
		cap = frames_effective(cfg_frames);
		res.was_hit = 1'b0;
		at = 0;
		for (int i = 0; i < resident_count; i++)
			if (!res.was_hit && resident[i] == pg) begin
				res.was_hit = 1'b1;
				at = i;
			end
		if (res.was_hit) begin
			if (cfg_policy == prf_pkg::POLICY_LRU) begin
				for (int i = at; i + 1 < resident_count; i++)
					resident[i] = resident[i + 1];
				resident[resident_count - 1] = pg;
			end
		end else begin
			// A shrunken frame count keeps only the newest entries on a miss.
			if (resident_count >= cap) begin
				drop = resident_count - (cap - 1);
				for (int i = 0; i + 1 < cap; i++)
					resident[i] = resident[i + drop];
				resident_count = cap - 1;
			end
			resident[resident_count] = pg;
			resident_count++;
			if (fault_tally != prf_pkg::FAULT_MAX)
				fault_tally++;
		end
		res.count = fault_tally;
	endfunction

	function automatic void note_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s at %0t ns: expected %0d, got %0d", what, $time, want, got);
	endfunction

	always @(posedge clk) begin
		lookup_t ent;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				page_lookup(page_number, ent);
				if (row_typed) begin
					ent.was_hit = row_hit;
					ent.count = row_count;
				end
				lookups_due.push_back(ent);
			end
			if (out_valid && out_ready) begin
				if (lookups_due.size() == 0) begin
					note_mismatch("result beat with nothing pending", 0, 1);
				end else begin
					ent = lookups_due.pop_front();
					if (hit !== ent.was_hit)
						note_mismatch("hit", ent.was_hit, hit);
					if (fault_count !== ent.count)
						note_mismatch("fault_count", ent.count, fault_count);
					beats_checked++;
					if (ent.was_hit)
						hits_seen++;
				end
			end
		end
	end

	// Receiver alternates ready runs, sometimes long, with short stalls.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_on = !rx_on;
			if (rx_on)
				rx_left = ($urandom_range(0, 7) == 0) ? 50 : $urandom_range(1, 12);
			else
				rx_left = $urandom_range(1, 3);
		end
		rx_left--;
		out_ready <= rx_on;
	end

	task automatic send_ref(input logic [prf_pkg::PAGE_IN_W-1:0] pg, input bit typed,
			input logic t_hit, input logic [prf_pkg::FAULT_W-1:0] t_count);
		@(negedge clk);
		in_valid <= 1'b1;
		page_number <= pg;
		row_typed <= typed;
		row_hit <= t_hit;
		row_count <= t_count;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic park_input(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
			page_number <= prf_pkg::PAGE_IN_W'($urandom);
		end
	endtask

	// Stop sending, wait for every outstanding result, then idle before returning.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (lookups_due.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic offer_ref(input logic [prf_pkg::PAGE_IN_W-1:0] pg, input bit typed = 1'b0,
			input logic t_hit = 1'b0, input logic [prf_pkg::FAULT_W-1:0] t_count = '0);
		if (burst_left == 0) begin
			if ($urandom_range(0, 30) == 0)
				settle();
			else
				park_input($urandom_range(0, 6));
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 12);
		end
		burst_left--;
		send_ref(pg, typed, t_hit, t_count);
	endtask

	task automatic reg_write(input logic [prf_pkg::REG_IDX_W-1:0] idx,
			input logic [prf_pkg::FRAMES_W-1:0] val);
		logic [prf_pkg::PDATA_W-1:0] wd;
		// Upper bits are noise; only the register's own width is taken.
		wd = prf_pkg::PDATA_W'($urandom);
		if (idx == prf_pkg::REG_POLICY_MODE)
			wd[0] = val[0];
		else
			wd[prf_pkg::FRAMES_W-1:0] = val;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= wd;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == prf_pkg::REG_POLICY_MODE) begin
			cfg_policy = val[0];
		end else begin
			cfg_frames = val;
			frames_visited[val] = 1'b1;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		logic [prf_pkg::PAGE_IN_W-1:0] pool [12];
		logic [prf_pkg::PAGE_IN_W-1:0] pg;
		logic [prf_pkg::FRAMES_W-1:0]  fr;
		logic                          pol;
		int                            pool_len;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		page_number = '0;
		for (int i = 0; i < SLOTS; i++)
			resident[i] = '0;
		resident_count = 0;
		fault_tally = '0;
		cfg_policy = prf_pkg::POLICY_RESET;
		cfg_frames = prf_pkg::FRAMES_RESET;
		frames_visited[prf_pkg::FRAMES_RESET] = 1'b1;

		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_CFG) begin
				settle();
				reg_write(directed_rows[r].reg_idx,
					directed_rows[r].val[prf_pkg::FRAMES_W-1:0]);
			end else begin
				offer_ref(directed_rows[r].val, directed_rows[r].typed, directed_rows[r].t_hit,
					directed_rows[r].t_count);
			end
		end

		// Random phases: each uses a working set of the effective frame count plus up to four pages.
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: fr = 4'd1;
				1: fr = 4'd8;
				2: fr = 4'd0;
				3: fr = 4'd15;
				default: fr = prf_pkg::FRAMES_W'($urandom_range(0, 15));
			endcase
			if (ph < 4)
				pol = ph[0] ? prf_pkg::POLICY_LRU : prf_pkg::POLICY_FIFO;
			else
				pol = $urandom_range(0, 1) ? prf_pkg::POLICY_LRU : prf_pkg::POLICY_FIFO;
			settle();
			if ($urandom_range(0, 1)) begin
				reg_write(prf_pkg::REG_POLICY_MODE, prf_pkg::FRAMES_W'(pol));
				reg_write(prf_pkg::REG_FRAMES_IN_USE, fr);
			end else begin
				reg_write(prf_pkg::REG_FRAMES_IN_USE, fr);
				reg_write(prf_pkg::REG_POLICY_MODE, prf_pkg::FRAMES_W'(pol));
			end
			pool_len = frames_effective(fr) + $urandom_range(0, 4);
			foreach (pool[i])
				pool[i] = prf_pkg::PAGE_IN_W'($urandom);
			repeat (150) begin
				if ($urandom_range(0, 3) != 0)
					pg = pool[$urandom_range(0, pool_len - 1)];
				else
					pg = prf_pkg::PAGE_IN_W'($urandom);
				offer_ref(pg);
			end
		end

		settle();
		$display("checked %0d result beats (%0d hits) over %0d frame settings in both policies",
			beats_checked, hits_seen, $countones(frames_visited));
		$display("frame counts were lowered below the occupancy and set out of range");
		if (mismatches == 0 && lookups_due.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
